// File: rtl/linear_probe_hash_table_assert.svh
// ----------------------------------------------------------------------------
// linear_probe_hash_table assertion macros
// Concurrent assertion helpers, compiled out when NO_ASSERTIONS is defined.
// ----------------------------------------------------------------------------
`ifndef LINEAR_PROBE_HASH_TABLE_ASSERT_SVH
`define LINEAR_PROBE_HASH_TABLE_ASSERT_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define LPHT_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lpht assertion failed");

// next-cycle implication
`define LPHT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lpht assertion failed");

`else

`define LPHT_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define LPHT_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// File: rtl/lpht_pkg.sv
// ----------------------------------------------------------------------------
// lpht_pkg
// Shared constants, codes and interface types of the linear probing hash table.
// ----------------------------------------------------------------------------
package lpht_pkg;

  localparam int TABLE_DEPTH = 16;
  localparam int KEY_WIDTH   = 31;

  localparam int IDX_W  = $clog2(TABLE_DEPTH);
  localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
  localparam int SIZE_W = 5;
  localparam int LOC_W  = 4;
  localparam int CMD_W  = 2;
  localparam int STAT_W = 2;
  localparam int CMP_W  = (CNT_W > SIZE_W) ? CNT_W : SIZE_W;

  // remainder unit: bits of the key consumed per cycle
  localparam int DIGITS    = 4;
  localparam int MOD_STEPS = (KEY_WIDTH + DIGITS - 1) / DIGITS;
  localparam int KEY_PAD   = MOD_STEPS * DIGITS;
  localparam int MCNT_W    = $clog2(MOD_STEPS + 1);

  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd1;
  localparam logic [CMD_W-1:0] CMD_DELETE = 2'd2;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK        = 2'd0,
    STAT_FULL      = 2'd1,
    STAT_NOT_FOUND = 2'd2,
    STAT_EMPTY     = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MOD,
    ST_PROBE,
    ST_RESP
  } state_t;

  typedef struct packed {
    logic                 start;
    logic [KEY_WIDTH-1:0] key;
    logic [CNT_W-1:0]     size;
  } mod_req_t;

  typedef struct packed {
    logic             done;
    logic [IDX_W-1:0] rem;
  } mod_rsp_t;

  typedef struct packed {
    logic                 we;
    logic [IDX_W-1:0]     waddr;
    logic [KEY_WIDTH-1:0] wdata;
    logic                 re;
    logic [IDX_W-1:0]     raddr;
  } ram_req_t;

endpackage

// File: rtl/linear_probe_hash_table.sv
// Full, empty and unknown commands reply without the remainder unit or probing;
//   others take the home slot from the remainder unit, then probe one slot per cycle.
// One command at a time: in_stall is high from accept until the reply is loaded
//   into the output register, which waits while full and out_stall is high.
// Reset: synchronous, clears valid bits and occupancy at once, table_size to 16.
// ----------------------------------------------------------------------------
// linear_probe_hash_table
// Open-addressing hash table with linear probing: insert, search, delete.
// ----------------------------------------------------------------------------
`include "linear_probe_hash_table_assert.svh"

module linear_probe_hash_table (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [lpht_pkg::SIZE_W-1:0]   cfg_table_size,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [lpht_pkg::CMD_W-1:0]    in_command,
  input  logic [lpht_pkg::KEY_WIDTH-1:0] in_key,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [lpht_pkg::STAT_W-1:0]   out_status,
  output logic [lpht_pkg::LOC_W-1:0]    out_location
);
  import lpht_pkg::*;

  state_t               state_r, state_nxt;
  logic [CMD_W-1:0]     cmd_r, cmd_nxt;
  logic [KEY_WIDTH-1:0] key_r, key_nxt;
  logic [SIZE_W-1:0]    tsize_r;
  logic [CNT_W-1:0]     occ_r, occ_nxt;
  logic [TABLE_DEPTH-1:0] valid_r, valid_nxt;
  logic [IDX_W-1:0]     pos_r, pos_nxt;
  logic [CNT_W-1:0]     issued_r, issued_nxt;
  logic                 pend_r, pend_nxt;
  logic [IDX_W-1:0]     pend_addr_r, pend_addr_nxt;
  status_t              res_status_r, res_status_nxt;
  logic [IDX_W-1:0]     res_loc_r, res_loc_nxt;
  logic                 out_valid_r, out_valid_nxt;
  status_t              out_status_r, out_status_nxt;
  logic [LOC_W-1:0]     out_loc_r, out_loc_nxt;

  logic [CNT_W-1:0]     eff;
  logic                 accept;
  logic                 out_free;
  logic                 quick;
  status_t              quick_status;
  logic [IDX_W-1:0]     wrap_pos;
  logic                 hit;
  logic                 ins_free;
  logic                 ins_last;
  logic                 scan_end;
  logic                 finish;

  mod_req_t             mod_req;
  mod_rsp_t             mod_rsp;
  ram_req_t             ram_req;
  logic [KEY_WIDTH-1:0] ram_rdata;

  lpht_mod_unit u_mod (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mod_req),
    .rsp   (mod_rsp)
  );

  lpht_key_ram u_ram (
    .clk   (clk),
    .req   (ram_req),
    .rdata (ram_rdata)
  );

  // effective size: zero acts as one, clipped to the depth
  always_comb begin
    if (tsize_r == '0) begin
      eff = CNT_W'(1);
    end else if (CMP_W'(tsize_r) > CMP_W'(TABLE_DEPTH)) begin
      eff = CNT_W'(TABLE_DEPTH);
    end else begin
      eff = CNT_W'(tsize_r);
    end
  end

  assign accept    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign cfg_ready = 1'b1;

  // commands decided without probing
  always_comb begin
    quick        = 1'b0;
    quick_status = STAT_NOT_FOUND;
    case (in_command)
      CMD_INSERT: begin
        if (CMP_W'(occ_r) >= CMP_W'(eff)) begin
          quick        = 1'b1;
          quick_status = STAT_FULL;
        end
      end
      CMD_SEARCH: begin
        quick = 1'b0;
      end
      CMD_DELETE: begin
        if (occ_r == '0) begin
          quick        = 1'b1;
          quick_status = STAT_EMPTY;
        end
      end
      default: begin
        quick        = 1'b1;
        quick_status = STAT_NOT_FOUND;
      end
    endcase
  end

  // probe walk evaluation
  always_comb begin
    wrap_pos = (CNT_W'(pos_r) + CNT_W'(1) == eff) ? '0 : pos_r + 1'b1;
    hit      = pend_r && valid_r[pend_addr_r] && (ram_rdata == key_r);
    ins_free = !valid_r[pos_r];
    ins_last = (issued_r + CNT_W'(1) == eff);
    scan_end = (issued_r == eff);
    if (cmd_r == CMD_INSERT) begin
      finish = ins_free || ins_last;
    end else begin
      finish = hit || scan_end;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = quick ? ST_RESP : ST_MOD;
        end
      end
      ST_MOD: begin
        if (mod_rsp.done) begin
          state_nxt = ST_PROBE;
        end
      end
      ST_PROBE: begin
        if (finish) begin
          state_nxt = ST_RESP;
        end
      end
      ST_RESP: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // datapath and outputs
  always_comb begin
    cmd_nxt        = cmd_r;
    key_nxt        = key_r;
    occ_nxt        = occ_r;
    valid_nxt      = valid_r;
    pos_nxt        = pos_r;
    issued_nxt     = issued_r;
    pend_nxt       = 1'b0;
    pend_addr_nxt  = pend_addr_r;
    res_status_nxt = res_status_r;
    res_loc_nxt    = res_loc_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_status_nxt = out_status_r;
    out_loc_nxt    = out_loc_r;
    mod_req.start  = 1'b0;
    mod_req.key    = in_key;
    mod_req.size   = eff;
    ram_req.we     = 1'b0;
    ram_req.waddr  = pos_r;
    ram_req.wdata  = key_r;
    ram_req.re     = 1'b0;
    ram_req.raddr  = pos_r;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          cmd_nxt        = in_command;
          key_nxt        = in_key;
          res_status_nxt = quick_status;
          res_loc_nxt    = '0;
          mod_req.start  = !quick;
        end
      end
      ST_MOD: begin
        pos_nxt    = mod_rsp.rem;
        issued_nxt = '0;
      end
      ST_PROBE: begin
        if (cmd_r == CMD_INSERT) begin
          if (ins_free) begin
            ram_req.we       = 1'b1;
            valid_nxt[pos_r] = 1'b1;
            occ_nxt          = occ_r + 1'b1;
            res_status_nxt   = STAT_OK;
            res_loc_nxt      = pos_r;
          end else if (ins_last) begin
            res_status_nxt = STAT_FULL;
            res_loc_nxt    = '0;
          end else begin
            pos_nxt    = wrap_pos;
            issued_nxt = issued_r + 1'b1;
          end
        end else begin
          if (hit) begin
            res_status_nxt = STAT_OK;
            res_loc_nxt    = pend_addr_r;
            if (cmd_r == CMD_DELETE) begin
              valid_nxt[pend_addr_r] = 1'b0;
              occ_nxt                = occ_r - 1'b1;
            end
          end else if (scan_end) begin
            res_status_nxt = STAT_NOT_FOUND;
            res_loc_nxt    = '0;
          end else begin
            // key read lands next cycle, compare then
            ram_req.re    = 1'b1;
            pend_nxt      = 1'b1;
            pend_addr_nxt = pos_r;
            pos_nxt       = wrap_pos;
            issued_nxt    = issued_r + 1'b1;
          end
        end
      end
      ST_RESP: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_loc_nxt    = LOC_W'(res_loc_r);
        end
      end
      default: begin
        pend_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      tsize_r     <= SIZE_W'(TABLE_DEPTH);
      occ_r       <= '0;
      valid_r     <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      occ_r       <= occ_nxt;
      valid_r     <= valid_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        tsize_r <= cfg_table_size;
      end
    end
    cmd_r        <= cmd_nxt;
    key_r        <= key_nxt;
    pos_r        <= pos_nxt;
    issued_r     <= issued_nxt;
    pend_addr_r  <= pend_addr_nxt;
    res_status_r <= res_status_nxt;
    res_loc_r    <= res_loc_nxt;
    out_status_r <= out_status_nxt;
    out_loc_r    <= out_loc_nxt;
  end

  assign in_stall     = (state_r != ST_IDLE);
  assign out_valid    = out_valid_r;
  assign out_status   = out_status_r;
  assign out_location = out_loc_r;

  `LPHT_ASSERT_IMPLIES(a_occ_matches_valid, clk, rst_n, 1'b1, $countones(valid_r) == int'(occ_r))
  `LPHT_ASSERT_IMPLIES(a_home_in_range, clk, rst_n, mod_rsp.done, CNT_W'(mod_rsp.rem) < eff)
  `LPHT_ASSERT_IMPLIES(a_loc_zero_on_fail, clk, rst_n,
    out_valid_r && (out_status_r != STAT_OK), out_loc_r == '0)
  `LPHT_ASSERT_NEXT(a_insert_counts, clk, rst_n, ram_req.we, occ_r == $past(occ_r) + 1'b1)

endmodule

// File: rtl/lpht_mod_unit.sv
// ----------------------------------------------------------------------------
// lpht_mod_unit
// Multi-cycle remainder of key by table size, several key bits per cycle.
// ----------------------------------------------------------------------------
module lpht_mod_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  lpht_pkg::mod_req_t req,
  output lpht_pkg::mod_rsp_t rsp
);
  import lpht_pkg::*;

  logic               busy_r, busy_nxt;
  logic               done_r, done_nxt;
  logic [MCNT_W-1:0]  cnt_r, cnt_nxt;
  logic [KEY_PAD-1:0] sh_r, sh_nxt;
  logic [CNT_W-1:0]   rem_r, rem_nxt;
  logic [CNT_W-1:0]   size_r, size_nxt;

  always_comb begin
    logic [CNT_W-1:0] r;
    logic [CNT_W:0]   t;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    sh_nxt   = sh_r;
    rem_nxt  = rem_r;
    size_nxt = size_r;
    r        = rem_r;
    t        = '0;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = MCNT_W'(MOD_STEPS);
      sh_nxt   = KEY_PAD'(req.key);
      rem_nxt  = '0;
      size_nxt = req.size;
    end else if (busy_r) begin
      // restoring remainder, msb first
      for (int j = 0; j < DIGITS; j++) begin
        t = {r, sh_r[KEY_PAD-1-j]};
        if (t >= {1'b0, size_r}) begin
          t = t - {1'b0, size_r};
        end
        r = t[CNT_W-1:0];
      end
      rem_nxt = r;
      sh_nxt  = sh_r << DIGITS;
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == MCNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    sh_r   <= sh_nxt;
    rem_r  <= rem_nxt;
    size_r <= size_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.rem  = rem_r[IDX_W-1:0];

endmodule

// File: rtl/lpht_key_ram.sv
// ----------------------------------------------------------------------------
// lpht_key_ram
// Slot key store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module lpht_key_ram (
  input  logic                           clk,
  input  lpht_pkg::ram_req_t             req,
  output logic [lpht_pkg::KEY_WIDTH-1:0] rdata
);
  import lpht_pkg::*;

  logic [KEY_WIDTH-1:0] mem [TABLE_DEPTH];
  logic [KEY_WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rdata_r <= mem[req.raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: tb/sv/linear_probe_hash_table_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// linear_probe_hash_table_tb
// Sends insert, search, delete and unused words to the hash table across a
// range of table sizes, with random sender gaps and receiver stalls, and
// checks every reply against a scoreboard's shadow copy of the slot store.
// ----------------------------------------------------------------------------
module linear_probe_hash_table_tb;
  import lpht_pkg::*;

  localparam int CLK_HALF     = 10;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 40;
  localparam int POOL_SIZE    = 24;

  localparam logic [CMD_W-1:0]     CMD_UNUSED = 2'd3;
  localparam logic [KEY_WIDTH-1:0] KEY_MAX    = {KEY_WIDTH{1'b1}};

  typedef struct {
    status_t          status;
    logic [LOC_W-1:0] location;
  } reply_t;

  class hash_table_scoreboard;
    logic [KEY_WIDTH-1:0] slot_key [TABLE_DEPTH];
    bit                   slot_used [TABLE_DEPTH];
    int unsigned          occupancy;
    int unsigned          size_reg;
    reply_t               expected_replies [$];
    int                   errors;

    function new();
      occupancy = 0;
      size_reg  = TABLE_DEPTH;
      errors    = 0;
      foreach (slot_used[i]) slot_used[i] = 1'b0;
    endfunction

    function void set_size(logic [SIZE_W-1:0] value);
      size_reg = 32'(value);
    endfunction

    // zero acts as one, anything past the depth as the depth
    function int unsigned active_size();
      if (size_reg == 0) return 1;
      if (size_reg > TABLE_DEPTH) return TABLE_DEPTH;
      return size_reg;
    endfunction

    // first live slot holding the key, scanning from home, or -1
    function int find_slot(logic [KEY_WIDTH-1:0] key, int unsigned sz);
      int unsigned home;
      int unsigned p;
      int unsigned i;
      home = key % sz;
      for (i = 0; i < sz; i++) begin
        p = (home + i) % sz;
        if (slot_used[p] && slot_key[p] == key) return p;
      end
      return -1;
    endfunction

    function void note_input(logic [CMD_W-1:0] cmd, logic [KEY_WIDTH-1:0] key);
      int unsigned sz;
      int unsigned home;
      int unsigned q;
      int unsigned i;
      int          hit;
      reply_t      r;
      sz         = active_size();
      r.status   = STAT_NOT_FOUND;
      r.location = '0;
      case (cmd)
        CMD_INSERT: begin
          r.status = STAT_FULL;
          if (occupancy < sz) begin
            home = key % sz;
            for (i = 0; i < sz; i++) begin
              q = (home + i) % sz;
              if (!slot_used[q]) begin
                slot_key[q]  = key;
                slot_used[q] = 1'b1;
                occupancy++;
                r.status   = STAT_OK;
                r.location = q[LOC_W-1:0];
                break;
              end
            end
          end
        end
        CMD_SEARCH: begin
          hit = find_slot(key, sz);
          if (hit >= 0) begin
            r.status   = STAT_OK;
            r.location = hit[LOC_W-1:0];
          end
        end
        CMD_DELETE: begin
          if (occupancy == 0) begin
            r.status = STAT_EMPTY;
          end else begin
            hit = find_slot(key, sz);
            if (hit >= 0) begin
              slot_used[hit] = 1'b0;
              occupancy--;
              r.status   = STAT_OK;
              r.location = hit[LOC_W-1:0];
            end
          end
        end
        default: begin
          // unused command leaves the table alone
        end
      endcase
      expected_replies.push_back(r);
    endfunction

    function void check_result(status_t st, logic [LOC_W-1:0] loc);
      reply_t want;
      if (expected_replies.size() == 0) begin
        $display("%0t: reply with none pending, status %0d location %0d", $time, st, loc);
        errors++;
        return;
      end
      want = expected_replies.pop_front();
      if (st !== want.status) begin
        $display("%0t: status mismatch, expected %0d actual %0d", $time, want.status, st);
        errors++;
      end
      if (loc !== want.location) begin
        $display("%0t: location mismatch, expected %0d actual %0d",
                 $time, want.location, loc);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return expected_replies.size();
    endfunction
  endclass

  logic                 clk            = 1'b0;
  logic                 rst_n          = 1'b0;
  logic                 cfg_valid      = 1'b0;
  logic                 cfg_ready;
  logic [SIZE_W-1:0]    cfg_table_size = '0;
  logic                 in_valid       = 1'b0;
  logic                 in_stall;
  logic [CMD_W-1:0]     in_command     = CMD_INSERT;
  logic [KEY_WIDTH-1:0] in_key         = '0;
  logic                 out_valid;
  logic                 out_stall      = 1'b0;
  logic [STAT_W-1:0]    out_status;
  logic [LOC_W-1:0]     out_location;

  hash_table_scoreboard sb = new();

  int unsigned cycle_count   = 0;
  int unsigned hold_requests = 0;
  int unsigned holds_served  = 0;
  int unsigned hold_left     = 0;
  int unsigned run_left      = 0;
  int unsigned burst_left    = 0;

  always #CLK_HALF clk = ~clk;

  linear_probe_hash_table dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_table_size (cfg_table_size),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_command     (in_command),
    .in_key         (in_key),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_status     (out_status),
    .out_location   (out_location)
  );

  // accepted words on both sides
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) sb.note_input(in_command, in_key);
    if (rst_n && out_valid && !out_stall) sb.check_result(status_t'(out_status), out_location);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // receiver: alternating stall and free runs, plus long hold-offs on request
  always @(posedge clk) begin
    if (hold_requests != holds_served) begin
      holds_served <= hold_requests;
      hold_left    <= HOLD_CYCLES;
      out_stall    <= 1'b1;
    end else if (hold_left > 1) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (run_left > 1) begin
      hold_left <= 0;
      run_left  <= run_left - 1;
    end else begin
      hold_left <= 0;
      if (out_stall) begin
        out_stall <= 1'b0;
        if ($urandom_range(0, 9) == 0) run_left <= $urandom_range(60, 150);
        else run_left <= $urandom_range(0, 12);
      end else begin
        out_stall <= 1'b1;
        run_left  <= $urandom_range(1, 6);
      end
    end
  end

  task automatic send_word(input logic [CMD_W-1:0] cmd, input logic [KEY_WIDTH-1:0] key);
    int unsigned gap;
    in_valid   <= 1'b1;
    in_command <= cmd;
    in_key     <= key;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end else begin
      burst_left--;
    end
  endtask

  task automatic write_table_size(input logic [SIZE_W-1:0] value);
    cfg_valid      <= 1'b1;
    cfg_table_size <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    sb.set_size(value);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic run_random_phase(input int unsigned count, input int unsigned insert_pct,
                                  input bit with_hold);
    logic [KEY_WIDTH-1:0] key_pool [POOL_SIZE];
    logic [31:0]          raw;
    logic [CMD_W-1:0]     cmd;
    logic [KEY_WIDTH-1:0] key;
    int unsigned          roll;
    int unsigned          n;
    // mix of small keys, wide keys with low bits 3, and wide random keys
    foreach (key_pool[i]) begin
      raw = $urandom;
      case ($urandom_range(0, 2))
        0:       key_pool[i] = KEY_WIDTH'($urandom_range(0, 40));
        1:       key_pool[i] = {raw[KEY_WIDTH-1:4], 4'd3};
        default: key_pool[i] = raw[KEY_WIDTH-1:0];
      endcase
    end
    for (n = 0; n < count; n++) begin
      if (with_hold && n == 10) hold_requests <= hold_requests + 1;
      roll = $urandom_range(0, 99);
      if (roll < insert_pct) cmd = CMD_INSERT;
      else if (roll < insert_pct + (97 - insert_pct) / 2) cmd = CMD_SEARCH;
      else if (roll < 97) cmd = CMD_DELETE;
      else cmd = CMD_UNUSED;
      raw = $urandom;
      if ($urandom_range(0, 6) != 0) key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
      else key = raw[KEY_WIDTH-1:0];
      send_word(cmd, key);
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset size: collisions, wraparound, duplicates, odd command, empty table
    send_word(CMD_SEARCH, 31'd0);
    send_word(CMD_DELETE, 31'd5);
    send_word(CMD_INSERT, 31'd0);
    send_word(CMD_INSERT, KEY_MAX);
    send_word(CMD_INSERT, 31'd16);
    send_word(CMD_INSERT, 31'd31);
    send_word(CMD_SEARCH, 31'd31);
    send_word(CMD_SEARCH, KEY_MAX);
    send_word(CMD_SEARCH, 31'd47);
    send_word(CMD_INSERT, 31'd0);
    send_word(CMD_DELETE, 31'd0);
    send_word(CMD_SEARCH, 31'd0);
    send_word(CMD_UNUSED, 31'h2AAAAAAA);
    send_word(CMD_UNUSED, 31'h55555555);
    send_word(CMD_DELETE, 31'd99);
    send_word(CMD_DELETE, 31'd16);
    send_word(CMD_DELETE, 31'd31);
    send_word(CMD_DELETE, 31'd0);
    send_word(CMD_DELETE, KEY_MAX);
    send_word(CMD_DELETE, 31'd0);
    wait_idle();

    // size zero behaves as a single slot
    write_table_size(5'd0);
    send_word(CMD_INSERT, 31'd7);
    send_word(CMD_INSERT, 31'd8);
    send_word(CMD_SEARCH, 31'd7);
    send_word(CMD_DELETE, 31'd7);
    send_word(CMD_DELETE, 31'd7);
    wait_idle();

    // oversize clamps to the depth; a long output hold-off stalls the input
    write_table_size(5'd31);
    run_random_phase(150, 45, 1'b1);
    wait_idle();

    // fill, then shrink with live slots past the new size
    write_table_size(5'd16);
    run_random_phase(16, 100, 1'b0);
    wait_idle();
    write_table_size(5'd4);
    run_random_phase(100, 40, 1'b0);
    wait_idle();

    // grow back and drain the stranded slots
    write_table_size(5'd16);
    run_random_phase(120, 20, 1'b0);
    wait_idle();

    write_table_size(5'd1);
    run_random_phase(60, 40, 1'b0);
    wait_idle();
    write_table_size(5'd2);
    run_random_phase(80, 50, 1'b0);
    wait_idle();
    write_table_size(5'd5);
    run_random_phase(120, 55, 1'b0);
    wait_idle();
    write_table_size(5'd7);
    run_random_phase(120, 45, 1'b0);
    wait_idle();
    write_table_size(5'd13);
    run_random_phase(120, 60, 1'b0);
    wait_idle();
    write_table_size(5'd20);
    run_random_phase(120, 50, 1'b0);
    wait_idle();
    write_table_size(5'd16);
    run_random_phase(120, 35, 1'b0);
    wait_idle();
    write_table_size(5'd3);
    run_random_phase(80, 45, 1'b0);
    wait_idle();

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
